[design/ciedu_pkg.sv]
package ciedu_pkg;

    localparam int MAX_REF_LEN_DEF = 64;
    localparam int CHAR_W = 8;
    localparam int DIST_W = 16;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_REF   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    // controller -> datapath
    typedef struct packed {
        logic ref_append;
        logic row_start;
        logic rd_issue;
        logic cell_calc;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ref_empty;
        logic idx_last;
    } sts_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        r = (v == DIST_SAT) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

[design/case_insensitive_edit_distance_unit.sv]
// Case-insensitive Levenshtein distance. Load the reference with func 0 beats (one byte
// each, first MAX_REF_LEN kept), send the query with func 1 beats, then a func 2 beat
// returns distance, ref_too_long and order_error on a one-cycle done strobe; the
// receiver cannot stall, so done must be sampled when it fires. Reference and end beats,
// and a query beat while the reference is empty, leave busy low. Otherwise a query beat
// keeps busy high while the row is walked, so no new beat is taken until it drops: the
// row store has one read port and the cell update walks it one cell per cycle. No
// clearing pass is needed after reset.
module case_insensitive_edit_distance_unit #(
    parameter int MAX_REF_LEN = ciedu_pkg::MAX_REF_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ciedu_pkg::FUNC_W-1:0]   func,
    input  logic [ciedu_pkg::CHAR_W-1:0]   char_code,
    output logic                           done,
    output logic [ciedu_pkg::DIST_W-1:0]   distance,
    output logic                           ref_too_long,
    output logic                           order_error
);
    import ciedu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ciedu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ciedu_dp #(
        .MAX_REF_LEN (MAX_REF_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .distance     (distance),
        .ref_too_long (ref_too_long),
        .order_error  (order_error)
    );

endmodule

[design/ciedu_ram.sv]
module ciedu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/ciedu_ctrl.sv]
module ciedu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  ciedu_pkg::sts_t   sts,
    output ciedu_pkg::cmd_t   cmd,
    output logic              busy
);
    import ciedu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        FUNC_REF:
                        begin
                            cmd.ref_append = 1'b1;
                        end
                        FUNC_QUERY:
                        begin
                            cmd.row_start = 1'b1;
                            if (!sts.ref_empty)
                            begin
                                state_next = S_READ;
                            end
                        end
                        FUNC_END:
                        begin
                            cmd.emit = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                // compute the cell read last cycle, fetch the next one unless this is the last cell
                cmd.cell_calc = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_read_then_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_RUN)
        else $error("read phase not followed by run");

    a_calc_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_calc |-> $past(cmd.rd_issue))
        else $error("cell computed without a prior read");

    a_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && sts.idx_last) |=> state_reg == S_IDLE)
        else $error("row walk did not stop at last cell");

endmodule

[design/ciedu_dp.sv]
module ciedu_dp #(
    parameter int MAX_REF_LEN = ciedu_pkg::MAX_REF_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ciedu_pkg::CHAR_W-1:0]   char_code,
    input  ciedu_pkg::cmd_t                cmd,
    output ciedu_pkg::sts_t                sts,
    output logic                           done,
    output logic [ciedu_pkg::DIST_W-1:0]   distance,
    output logic                           ref_too_long,
    output logic                           order_error
);
    import ciedu_pkg::*;

    localparam int CW  = $clog2(MAX_REF_LEN + 1);
    localparam int RAW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;

    logic [CW-1:0]     ref_len_reg;
    logic [DIST_W-1:0] qcnt_reg;
    logic              too_long_reg;
    logic              order_reg;
    logic [CW-1:0]     idx_reg;
    logic              first_reg;
    logic [CHAR_W-1:0] qch_reg;
    logic [DIST_W-1:0] left_reg;
    logic [DIST_W-1:0] diag_reg;
    logic [DIST_W-1:0] last_reg;
    logic              done_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              flag_long_reg;
    logic              flag_order_reg;

    logic              ref_we;
    logic [CHAR_W-1:0] ref_rdata;
    logic [DIST_W-1:0] dp_rdata;
    logic [CW-1:0]     dp_raddr;

    logic [DIST_W-1:0] up;
    logic              cost;
    logic [DIST_W:0]   cand_l;
    logic [DIST_W:0]   cand_u;
    logic [DIST_W:0]   cand_d;
    logic [DIST_W:0]   best;
    logic [DIST_W-1:0] cell_val;

    assign ref_we   = cmd.ref_append && (qcnt_reg == '0) &&
                      (ref_len_reg != CW'(MAX_REF_LEN));
    assign dp_raddr = idx_reg + 1'b1;

    ciedu_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_REF_LEN),
        .AW    (RAW)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_len_reg[RAW-1:0]),
        .wdata (char_code),
        .raddr (idx_reg[RAW-1:0]),
        .rdata (ref_rdata)
    );

    ciedu_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_REF_LEN + 1),
        .AW    (CW)
    ) u_row_ram (
        .clk   (clk),
        .we    (cmd.cell_calc),
        .waddr (idx_reg),
        .wdata (cell_val),
        .raddr (dp_raddr),
        .rdata (dp_rdata)
    );

    // on the first query beat the previous row is 0..ref_len, never read from memory
    always_comb
    begin
        up     = first_reg ? DIST_W'(idx_reg) : dp_rdata;
        cost   = (fold_case(ref_rdata) != qch_reg);
        cand_l = {1'b0, left_reg} + 1'b1;
        cand_u = {1'b0, up} + 1'b1;
        cand_d = {1'b0, diag_reg} + {{DIST_W{1'b0}}, cost};
        best   = cand_l;
        if (cand_u < best)
        begin
            best = cand_u;
        end
        if (cand_d < best)
        begin
            best = cand_d;
        end
        cell_val = best[DIST_W] ? DIST_SAT : best[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg  <= '0;
            qcnt_reg     <= '0;
            too_long_reg <= 1'b0;
            order_reg    <= 1'b0;
            idx_reg      <= '0;
            first_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.ref_append)
            begin
                if (qcnt_reg != '0)
                begin
                    order_reg <= 1'b1;
                end
                else if (ref_len_reg == CW'(MAX_REF_LEN))
                begin
                    too_long_reg <= 1'b1;
                end
                else
                begin
                    ref_len_reg <= ref_len_reg + 1'b1;
                end
            end
            if (cmd.row_start)
            begin
                first_reg <= (qcnt_reg == '0);
                qcnt_reg  <= sat_inc(qcnt_reg);
                idx_reg   <= '0;
            end
            if (cmd.rd_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                ref_len_reg  <= '0;
                qcnt_reg     <= '0;
                too_long_reg <= 1'b0;
                order_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            qch_reg  <= fold_case(char_code);
            diag_reg <= qcnt_reg;
            left_reg <= sat_inc(qcnt_reg);
            last_reg <= sat_inc(qcnt_reg);
        end
        if (cmd.cell_calc)
        begin
            diag_reg <= up;
            left_reg <= cell_val;
            last_reg <= cell_val;
        end
        if (cmd.emit)
        begin
            dist_reg       <= (qcnt_reg == '0) ? DIST_W'(ref_len_reg) : last_reg;
            flag_long_reg  <= too_long_reg;
            flag_order_reg <= order_reg;
        end
    end

    assign sts.ref_empty = (ref_len_reg == '0);
    assign sts.idx_last  = (idx_reg == ref_len_reg);

    assign done         = done_reg;
    assign distance     = dist_reg;
    assign ref_too_long = flag_long_reg;
    assign order_error  = flag_order_reg;

    a_cleared_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (ref_len_reg == '0 && qcnt_reg == '0 && !too_long_reg && !order_reg))
        else $error("pair state not cleared after result beat");

    a_qcnt_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_start |=> qcnt_reg != '0)
        else $error("query count did not advance");

endmodule
